// ----- src/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Opcodes, stream widths and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

   // default datapath width and fixed field widths
   localparam int WIDTH_DEF   = 32;
   localparam int DATA_W      = 32;
   localparam int OPCODE_W    = 4;
   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 72;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_ADD = 4'd0;
   localparam logic [OPCODE_W-1:0] OP_SUB = 4'd1;
   localparam logic [OPCODE_W-1:0] OP_MUL = 4'd2;
   localparam logic [OPCODE_W-1:0] OP_DIV = 4'd3;
   localparam logic [OPCODE_W-1:0] OP_EQ  = 4'd4;
   localparam logic [OPCODE_W-1:0] OP_LT  = 4'd5;
   localparam logic [OPCODE_W-1:0] OP_LE  = 4'd6;
   localparam logic [OPCODE_W-1:0] OP_GT  = 4'd7;
   localparam logic [OPCODE_W-1:0] OP_GE  = 4'd8;

   // which cross product the shared multiplier forms this cycle
   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_P0,
      MUL_P1,
      MUL_P2
   } mul_step_type;

   // operand pair for the divider
   typedef enum logic [1:0] {
      DSRC_GCD,
      DSRC_NUM,
      DSRC_DEN
   } div_src_type;

   // controller -> datapath
   typedef struct packed {
      logic         load;
      mul_step_type mul_step;
      logic         form;
      logic         gcd_init;
      logic         div_start;
      div_src_type  div_src;
      logic         gcd_update;
      logic         num_update;
      logic         den_update;
      logic         sign_fix;
      logic         out_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_done;
      logic gx_zero;
      logic gy_zero;
      logic op_arith;
   } status_type;

endpackage

// ----- src/rau_divider.sv -----
// ----------------------------------------------------------------------------
// rau_divider: iterative signed divider
// Restoring radix-2 division on magnitudes, one quotient bit per cycle,
// truncated quotient and remainder with the remainder taking the
// dividend's sign. Results wrap to WIDTH bits.
// ----------------------------------------------------------------------------
module rau_divider #(
   parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);
   localparam int CNT_W = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic             neg_q_ff, neg_q_in;
   logic             neg_r_ff, neg_r_in;

   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;

   // one restoring step
   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(WIDTH);
         rem_in   = '0;
         quo_in   = dividend[WIDTH-1] ? -dividend : dividend;
         dsr_in   = divisor[WIDTH-1] ? -divisor : divisor;
         neg_q_in = dividend[WIDTH-1] ^ divisor[WIDTH-1];
         neg_r_in = dividend[WIDTH-1];
      end else if (busy_ff) begin
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dsr_ff   <= dsr_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   // restore signs
   assign done      = done_ff;
   assign quotient  = neg_q_ff ? -quo_ff : quo_ff;
   assign remainder = neg_r_ff ? -rem_ff : rem_ff;

endmodule

// ----- src/rau_datapath.sv -----
// ----------------------------------------------------------------------------
// rau_datapath: operand registers, shared multiplier, gcd and result
// Holds the item, forms cross products one per cycle, runs the Euclid
// registers around the shared divider and builds the result word.
// ----------------------------------------------------------------------------
module rau_datapath #(
   parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rau_pkg::cmd_type                cmd,
   output rau_pkg::status_type             status,
   input  logic [rau_pkg::OPCODE_W-1:0]    opcode,
   input  logic [rau_pkg::DATA_W-1:0]      a_num,
   input  logic [rau_pkg::DATA_W-1:0]      a_den,
   input  logic [rau_pkg::DATA_W-1:0]      b_num,
   input  logic [rau_pkg::DATA_W-1:0]      b_den,
   output logic [rau_pkg::RSP_TDATA_W-1:0] rsp_data
);
   import rau_pkg::*;

   logic [OPCODE_W-1:0]    op_ff;
   logic [WIDTH-1:0]       an_ff, ad_ff, bn_ff, bd_ff;
   logic [WIDTH-1:0]       p0_ff, p1_ff, p2_ff;
   logic [WIDTH-1:0]       num_ff, den_ff;
   logic [WIDTH-1:0]       gx_ff, gy_ff;
   logic [RSP_TDATA_W-1:0] rsp_ff, rsp_in;

   logic [WIDTH-1:0]       mul_a, mul_b;
   logic [2*WIDTH-1:0]     prod;
   logic [WIDTH-1:0]       num_form, den_form;
   logic [WIDTH-1:0]       div_dvd, div_dsr;
   logic                   div_done;
   logic [WIDTH-1:0]       div_quo, div_rem;
   logic                   op_arith;
   logic                   cmp_ok, cmp_bit;
   logic [DATA_W-1:0]      res_num, res_den;
   logic                   res_cmp, res_undef;

   assign op_arith = (op_ff <= OP_DIV);

   // operand select for the shared multiplier
   always_comb begin
      mul_a = ad_ff;
      mul_b = bd_ff;
      unique case (cmd.mul_step)
         MUL_P0: begin
            mul_a = an_ff;
            mul_b = (op_ff == OP_MUL) ? bn_ff : bd_ff;
         end
         MUL_P1: begin
            mul_a = ad_ff;
            mul_b = (op_ff == OP_MUL) ? bd_ff : bn_ff;
         end
         MUL_P2,
         MUL_NONE: begin
            mul_a = ad_ff;
            mul_b = bd_ff;
         end
         default: begin
            mul_a = ad_ff;
            mul_b = bd_ff;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // raw numerator and denominator from the cross products
   always_comb begin
      num_form = p0_ff;
      den_form = p1_ff;
      unique case (op_ff)
         OP_ADD: begin
            num_form = p0_ff + p1_ff;
            den_form = p2_ff;
         end
         OP_SUB: begin
            num_form = p0_ff - p1_ff;
            den_form = p2_ff;
         end
         default: begin
            num_form = p0_ff;
            den_form = p1_ff;
         end
      endcase
   end

   // divider operands
   always_comb begin
      div_dvd = gx_ff;
      div_dsr = gy_ff;
      unique case (cmd.div_src)
         DSRC_GCD: begin
            div_dvd = gx_ff;
            div_dsr = gy_ff;
         end
         DSRC_NUM: begin
            div_dvd = num_ff;
            div_dsr = gx_ff;
         end
         DSRC_DEN: begin
            div_dvd = den_ff;
            div_dsr = gx_ff;
         end
         default: begin
            div_dvd = gx_ff;
            div_dsr = gy_ff;
         end
      endcase
   end

   rau_divider #(
      .WIDTH (WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // item capture and products
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= opcode;
         an_ff <= a_num[WIDTH-1:0];
         ad_ff <= a_den[WIDTH-1:0];
         bn_ff <= b_num[WIDTH-1:0];
         bd_ff <= b_den[WIDTH-1:0];
      end
      if (cmd.mul_step == MUL_P0) p0_ff <= prod[WIDTH-1:0];
      if (cmd.mul_step == MUL_P1) p1_ff <= prod[WIDTH-1:0];
      if (cmd.mul_step == MUL_P2) p2_ff <= prod[WIDTH-1:0];
   end

   // fraction and Euclid registers
   always_ff @(posedge clock) begin
      if (cmd.form) begin
         num_ff <= num_form;
         den_ff <= den_form;
      end else if (cmd.sign_fix) begin
         if (den_ff[WIDTH-1]) begin
            num_ff <= -num_ff;
            den_ff <= -den_ff;
         end
      end else begin
         if (cmd.num_update) num_ff <= div_quo;
         if (cmd.den_update) den_ff <= div_quo;
      end
      if (cmd.gcd_init) begin
         gx_ff <= num_ff;
         gy_ff <= den_ff;
      end else if (cmd.gcd_update) begin
         gx_ff <= gy_ff;
         gy_ff <= div_rem;
      end
   end

   // comparison on wrapped cross products
   assign cmp_ok = (ad_ff != '0) && (bd_ff != '0);

   always_comb begin
      cmp_bit = 1'b0;
      unique case (op_ff)
         OP_EQ:   cmp_bit = (p0_ff == p1_ff);
         OP_LT:   cmp_bit = ($signed(p0_ff) <  $signed(p1_ff));
         OP_LE:   cmp_bit = ($signed(p0_ff) <= $signed(p1_ff));
         OP_GT:   cmp_bit = ($signed(p0_ff) >  $signed(p1_ff));
         OP_GE:   cmp_bit = ($signed(p0_ff) >= $signed(p1_ff));
         default: cmp_bit = 1'b0;
      endcase
   end

   // result word, sign-extended to the port width
   always_comb begin
      res_num   = '0;
      res_den   = '0;
      res_cmp   = 1'b0;
      res_undef = 1'b0;
      if (op_arith) begin
         res_num   = DATA_W'(signed'(num_ff));
         res_den   = DATA_W'(signed'(den_ff));
         res_undef = (den_ff == '0);
      end else begin
         res_cmp = cmp_ok & cmp_bit;
      end
      rsp_in = {6'd0, res_undef, res_cmp, res_den, res_num};
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   // status toward the controller
   assign status.div_done = div_done;
   assign status.gx_zero  = (gx_ff == '0);
   assign status.gy_zero  = (gy_ff == '0);
   assign status.op_arith = op_arith;

endmodule

// ----- src/rau_ctrl.sv -----
// ----------------------------------------------------------------------------
// rau_ctrl: sequencing state machine
// Steps one item through products and, for arithmetic, the Euclid loop,
// the two reducing divisions and the sign fix, and owns the output valid flag.
// ----------------------------------------------------------------------------
module rau_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  rau_pkg::status_type status,
   output rau_pkg::cmd_type    cmd
);
   import rau_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_FORM,
      S_GCD_INIT,
      S_GCD_TEST,
      S_GCD_WAIT,
      S_DIV_NUM,
      S_DIV_DEN,
      S_FIX,
      S_WRITE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      slot_free;

   assign slot_free  = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            cmd.mul_step = MUL_P0;
            state_in     = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul_step = MUL_P1;
            state_in     = status.op_arith ? S_MUL2 : S_WRITE;
         end
         S_MUL2: begin
            cmd.mul_step = MUL_P2;
            state_in     = S_FORM;
         end
         S_FORM: begin
            cmd.form = 1'b1;
            state_in = S_GCD_INIT;
         end
         S_GCD_INIT: begin
            cmd.gcd_init = 1'b1;
            state_in     = S_GCD_TEST;
         end
         S_GCD_TEST: begin
            priority if (!status.gy_zero) begin
               cmd.div_start = 1'b1;
               cmd.div_src   = DSRC_GCD;
               state_in      = S_GCD_WAIT;
            end else if (status.gx_zero) begin
               // zero gcd: leave the fraction unreduced
               state_in = S_FIX;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_src   = DSRC_NUM;
               state_in      = S_DIV_NUM;
            end
         end
         S_GCD_WAIT: begin
            if (status.div_done) begin
               cmd.gcd_update = 1'b1;
               state_in       = S_GCD_TEST;
            end
         end
         S_DIV_NUM: begin
            if (status.div_done) begin
               cmd.num_update = 1'b1;
               cmd.div_start  = 1'b1;
               cmd.div_src    = DSRC_DEN;
               state_in       = S_DIV_DEN;
            end
         end
         S_DIV_DEN: begin
            if (status.div_done) begin
               cmd.den_update = 1'b1;
               state_in       = S_FIX;
            end
         end
         S_FIX: begin
            cmd.sign_fix = 1'b1;
            state_in     = S_WRITE;
         end
         S_WRITE: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output valid: set on load, cleared on transfer
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (cmd.out_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

endmodule

// ----- src/rational_arith_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arith_unit: fraction arithmetic and comparison with gcd reduction
// Compares go straight from the products to the result; arithmetic runs
// the Euclid remainder steps, then the two reducing divisions, which a
// zero gcd skips.
// Throughput: one item at a time; the next request is taken in the cycle
// after the result is loaded.
// Reset: synchronous, active high; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module rational_arith_unit #(
   parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // opcode[3:0], a_num[35:4], a_den[67:36], b_num[99:68], b_den[131:100]
   input  logic [rau_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // res_num[31:0], res_den[63:32], compare_true[64], undefined_result[65]
   output logic [rau_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready
);
   import rau_pkg::*;

   cmd_type             cmd;
   status_type          status;
   logic [OPCODE_W-1:0] opcode;
   logic [DATA_W-1:0]   a_num, a_den, b_num, b_den;

   // unpack the request word
   assign opcode = req_tdata[3:0];
   assign a_num  = req_tdata[35:4];
   assign a_den  = req_tdata[67:36];
   assign b_num  = req_tdata[99:68];
   assign b_den  = req_tdata[131:100];

   rau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rau_datapath #(
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .opcode   (opcode),
      .a_num    (a_num),
      .a_den    (a_den),
      .b_num    (b_num),
      .b_den    (b_den),
      .rsp_data (rsp_tdata)
   );

endmodule
